@@ rtl/rtptf_pkg.sv @@
// ----------------------------------------------------------------------------
// rtptf_pkg
// Shared types and constants of the rgb to tensor pixel format writer:
// format and status codes, register map, configuration and queue entry types.
// ----------------------------------------------------------------------------
package rtptf_pkg;

  // field widths
  localparam int ADDR_W  = 28;
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 2;
  localparam int FMT_W   = 3;
  localparam int DIM_W   = 13;
  localparam int PITCH_W = 14;
  localparam int ROW_W   = 15;  // row stride, up to three times the width
  localparam int CROW_W  = 13;  // i420 chroma stride
  localparam int XOFF_W  = 15;  // column byte offset, up to three times the column

  // default limits
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int QUEUE_DEPTH    = 4;

  // configuration bus
  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  // register indexes
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_PITCH  = 2'd3;

  // output formats
  localparam logic [FMT_W-1:0] FMT_RGB_PACKED = 3'd0;
  localparam logic [FMT_W-1:0] FMT_BGR_PACKED = 3'd1;
  localparam logic [FMT_W-1:0] FMT_RGB_PLANAR = 3'd2;
  localparam logic [FMT_W-1:0] FMT_BGR_PLANAR = 3'd3;
  localparam logic [FMT_W-1:0] FMT_GRAY       = 3'd4;
  localparam logic [FMT_W-1:0] FMT_NV12       = 3'd5;
  localparam logic [FMT_W-1:0] FMT_NV21       = 3'd6;
  localparam logic [FMT_W-1:0] FMT_I420       = 3'd7;

  // result status
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_SIZE = 2'd1;
  localparam logic [STAT_W-1:0] ST_ODD  = 2'd2;

  // step index of the last write of an item
  localparam logic [1:0] LAST_ONE   = 2'd0;
  localparam logic [1:0] LAST_THREE = 2'd2;

  // bt.601 coefficients
  localparam int unsigned Y_R = 77;
  localparam int unsigned Y_G = 150;
  localparam int unsigned Y_B = 29;
  localparam int unsigned C_HALF = 128;
  localparam int unsigned U_R = 43;   // subtracted
  localparam int unsigned U_G = 85;   // subtracted
  localparam int unsigned V_G = 107;  // subtracted
  localparam int unsigned V_B = 21;   // subtracted
  localparam int unsigned C_BIAS = 32896;  // rounding plus offset that keeps chroma sums positive

  typedef struct packed {
    logic [FMT_W-1:0]   fmt;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [PITCH_W-1:0] pitch;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr0;
    logic [ADDR_W-1:0] addr1;
    logic [ADDR_W-1:0] addr2;
    logic [BYTE_W-1:0] val0;
    logic [BYTE_W-1:0] val1;
    logic [BYTE_W-1:0] val2;
    logic [STAT_W-1:0] status;
    logic [1:0]        last_idx;
  } qent_t;

endpackage

@@ rtl/rtptf_front.sv @@
// ----------------------------------------------------------------------------
// rtptf_front
// Accepts pixels, tracks column and row, checks the frame size, computes
// luma, chroma and the address products, then forms the write list of the
// item and hands it to the queue.
// ----------------------------------------------------------------------------
module rtptf_front #(
  parameter int MAX_WIDTH  = rtptf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rtptf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rtptf_pkg::cfg_t           cfg,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [7:0]                in_red,
  input  logic [7:0]                in_green,
  input  logic [7:0]                in_blue,
  input  logic                      in_frame_start,
  output logic                      q_push,
  input  logic                      q_full,
  output rtptf_pkg::qent_t          q_data
);

  localparam int CW = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
  localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW = rtptf_pkg::ADDR_W;
  localparam int CMP_W = rtptf_pkg::DIM_W + 1;

  logic            accept;
  logic [CW-1:0]   col_r, col_nxt, col0;
  logic [RW-1:0]   row_r, row_nxt, row0;
  logic [CMP_W-1:0] col_inc, row_inc;
  logic            col_wrap;
  logic [rtptf_pkg::STAT_W-1:0] status;
  logic            packed_fmt, i420_fmt;
  logic [rtptf_pkg::ROW_W-1:0]  row_stride, chroma_stride;
  logic [rtptf_pkg::CROW_W-1:0] crow;
  logic [16:0]     luma_sum, u_sum, v_sum;

  // stage one registers
  logic                         s1_valid_r, s1_valid_nxt;
  logic [rtptf_pkg::FMT_W-1:0]  s1_fmt_r;
  logic [rtptf_pkg::STAT_W-1:0] s1_status_r;
  logic [rtptf_pkg::XOFF_W-1:0] s1_xo_r;
  logic [rtptf_pkg::CROW_W-1:0] s1_xc_r;
  logic                         s1_even_r;
  logic [AW-1:0]                s1_pyr_r, s1_phr_r, s1_pc_r, s1_pch_r;
  logic [7:0]                   s1_r_r, s1_g_r, s1_b_r;
  logic [7:0]                   s1_luma_r, s1_u_r, s1_v_r;

  logic [AW-1:0]   lin, cbase;

  assign in_full = s1_valid_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = s1_valid_r && !q_full;

  // frame start clears the position before the pixel is used
  assign col0 = in_frame_start ? '0 : col_r;
  assign row0 = in_frame_start ? '0 : row_r;

  // size check
  always_comb begin
    if (cfg.width == '0 || cfg.height == '0 ||
        CMP_W'(cfg.width) > CMP_W'(MAX_WIDTH) || CMP_W'(cfg.height) > CMP_W'(MAX_HEIGHT)) begin
      status = rtptf_pkg::ST_SIZE;
    end else if (cfg.fmt >= rtptf_pkg::FMT_NV12 && (cfg.width[0] || cfg.height[0])) begin
      status = rtptf_pkg::ST_ODD;
    end else begin
      status = rtptf_pkg::ST_OK;
    end
  end

  // position counters
  always_comb begin
    col_inc  = CMP_W'(col0) + CMP_W'(1);
    col_wrap = col_inc >= CMP_W'(cfg.width);
    row_inc  = CMP_W'(row0) + CMP_W'(col_wrap);
    col_nxt  = col0;
    row_nxt  = row0;
    if (status == rtptf_pkg::ST_OK) begin
      col_nxt = col_wrap ? '0 : col_inc[CW-1:0];
      row_nxt = (row_inc >= CMP_W'(cfg.height)) ? '0 : row_inc[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // row strides
  always_comb begin
    packed_fmt = (cfg.fmt == rtptf_pkg::FMT_RGB_PACKED) || (cfg.fmt == rtptf_pkg::FMT_BGR_PACKED);
    i420_fmt   = (cfg.fmt == rtptf_pkg::FMT_I420);
    if (cfg.pitch != '0) begin
      row_stride = rtptf_pkg::ROW_W'(cfg.pitch);
      crow       = rtptf_pkg::CROW_W'(cfg.pitch >> 1);
    end else begin
      row_stride = packed_fmt ? rtptf_pkg::ROW_W'(cfg.width) * rtptf_pkg::ROW_W'(3)
                              : rtptf_pkg::ROW_W'(cfg.width);
      crow       = rtptf_pkg::CROW_W'(cfg.width >> 1);
    end
    chroma_stride = i420_fmt ? rtptf_pkg::ROW_W'(crow) : row_stride;
  end

  // color sums, chroma kept nonnegative by the bias
  always_comb begin
    luma_sum = 17'(rtptf_pkg::Y_R) * 17'(in_red) + 17'(rtptf_pkg::Y_G) * 17'(in_green)
             + 17'(rtptf_pkg::Y_B) * 17'(in_blue) + 17'(rtptf_pkg::C_HALF);
    u_sum = 17'(rtptf_pkg::C_BIAS) + {2'b00, in_blue, 7'd0}
          - 17'(rtptf_pkg::U_R) * 17'(in_red) - 17'(rtptf_pkg::U_G) * 17'(in_green);
    v_sum = 17'(rtptf_pkg::C_BIAS) + {2'b00, in_red, 7'd0}
          - 17'(rtptf_pkg::V_G) * 17'(in_green) - 17'(rtptf_pkg::V_B) * 17'(in_blue);
  end

  // stage one valid
  always_comb begin
    s1_valid_nxt = accept || (s1_valid_r && q_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // stage one payload, one multiplier per product
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_fmt_r    <= cfg.fmt;
      s1_status_r <= status;
      s1_xo_r     <= packed_fmt ? rtptf_pkg::XOFF_W'(col0) * rtptf_pkg::XOFF_W'(3)
                                : rtptf_pkg::XOFF_W'(col0);
      s1_xc_r     <= i420_fmt ? rtptf_pkg::CROW_W'(col0 >> 1) : rtptf_pkg::CROW_W'(col0);
      s1_even_r   <= !col0[0] && !row0[0];
      s1_pyr_r    <= AW'(row0) * AW'(row_stride);
      s1_phr_r    <= AW'(cfg.height) * AW'(row_stride);
      s1_pc_r     <= AW'(row0 >> 1) * AW'(chroma_stride);
      s1_pch_r    <= AW'(crow) * AW'(cfg.height >> 1);
      s1_r_r      <= in_red;
      s1_g_r      <= in_green;
      s1_b_r      <= in_blue;
      s1_luma_r   <= luma_sum[15:8];
      s1_u_r      <= u_sum[16] ? 8'hff : u_sum[15:8];
      s1_v_r      <= v_sum[16] ? 8'hff : v_sum[15:8];
    end
  end

  // write list of the item
  assign lin   = s1_pyr_r + AW'(s1_xo_r);
  assign cbase = s1_phr_r + s1_pc_r + AW'(s1_xc_r);

  always_comb begin
    q_data          = '0;
    q_data.status   = s1_status_r;
    q_data.last_idx = rtptf_pkg::LAST_ONE;
    if (s1_status_r == rtptf_pkg::ST_OK) begin
      case (s1_fmt_r)
        rtptf_pkg::FMT_RGB_PACKED, rtptf_pkg::FMT_BGR_PACKED: begin
          q_data.addr0    = lin;
          q_data.addr1    = lin + AW'(1);
          q_data.addr2    = lin + AW'(2);
          q_data.val1     = s1_g_r;
          q_data.val0     = (s1_fmt_r == rtptf_pkg::FMT_BGR_PACKED) ? s1_b_r : s1_r_r;
          q_data.val2     = (s1_fmt_r == rtptf_pkg::FMT_BGR_PACKED) ? s1_r_r : s1_b_r;
          q_data.last_idx = rtptf_pkg::LAST_THREE;
        end
        rtptf_pkg::FMT_RGB_PLANAR, rtptf_pkg::FMT_BGR_PLANAR: begin
          q_data.addr0    = lin;
          q_data.addr1    = s1_phr_r + lin;
          q_data.addr2    = {s1_phr_r[AW-2:0], 1'b0} + lin;
          q_data.val1     = s1_g_r;
          q_data.val0     = (s1_fmt_r == rtptf_pkg::FMT_BGR_PLANAR) ? s1_b_r : s1_r_r;
          q_data.val2     = (s1_fmt_r == rtptf_pkg::FMT_BGR_PLANAR) ? s1_r_r : s1_b_r;
          q_data.last_idx = rtptf_pkg::LAST_THREE;
        end
        rtptf_pkg::FMT_GRAY: begin
          q_data.addr0 = lin;
          q_data.val0  = s1_luma_r;
        end
        default: begin
          // yuv: luma, then chroma pair on the top-left pixel of each block
          q_data.addr0    = lin;
          q_data.val0     = s1_luma_r;
          q_data.addr1    = cbase;
          q_data.addr2    = (s1_fmt_r == rtptf_pkg::FMT_I420) ? cbase + s1_pch_r
                                                              : cbase + AW'(1);
          q_data.val1     = (s1_fmt_r == rtptf_pkg::FMT_NV21) ? s1_v_r : s1_u_r;
          q_data.val2     = (s1_fmt_r == rtptf_pkg::FMT_NV21) ? s1_u_r : s1_v_r;
          q_data.last_idx = s1_even_r ? rtptf_pkg::LAST_THREE : rtptf_pkg::LAST_ONE;
        end
      endcase
    end
  end

endmodule

@@ rtl/rtptf_queue.sv @@
// ----------------------------------------------------------------------------
// rtptf_queue
// Short first-in first-out queue of item write lists between the front and
// back parts, in flip-flops, with full and empty decoded from the fill count.
// ----------------------------------------------------------------------------
module rtptf_queue #(
  parameter int DEPTH = rtptf_pkg::QUEUE_DEPTH,
  parameter int WIDTH = $bits(rtptf_pkg::qent_t)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == NW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + NW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ rtl/rtptf_back.sv @@
// ----------------------------------------------------------------------------
// rtptf_back
// Walks the write list at the queue head, one byte write per cycle unless
// stalled, into an output register that holds a result until it is taken.
// ----------------------------------------------------------------------------
module rtptf_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rtptf_pkg::qent_t                   q_data,
  input  logic                               q_empty,
  output logic                               q_pop,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [rtptf_pkg::ADDR_W-1:0]       out_byte_address,
  output logic [rtptf_pkg::BYTE_W-1:0]       out_byte_value,
  output logic [rtptf_pkg::STAT_W-1:0]       out_status,
  output logic                               out_last_of_pixel
);

  logic [1:0] step_r, step_nxt;
  logic       ov_r, ov_nxt;
  logic       load, last;
  logic [rtptf_pkg::ADDR_W-1:0] addr_sel;
  logic [rtptf_pkg::BYTE_W-1:0] val_sel;

  logic [rtptf_pkg::ADDR_W-1:0] addr_r;
  logic [rtptf_pkg::BYTE_W-1:0] val_r;
  logic [rtptf_pkg::STAT_W-1:0] status_r;
  logic                         last_r;

  assign load  = !q_empty && (!ov_r || out_pop);
  assign last  = (step_r == q_data.last_idx);
  assign q_pop = load && last;

  // pick the write of the current step
  always_comb begin
    case (step_r)
      2'd0: begin
        addr_sel = q_data.addr0;
        val_sel  = q_data.val0;
      end
      2'd1: begin
        addr_sel = q_data.addr1;
        val_sel  = q_data.val1;
      end
      default: begin
        addr_sel = q_data.addr2;
        val_sel  = q_data.val2;
      end
    endcase
  end

  // step counter and output valid
  always_comb begin
    step_nxt = step_r;
    if (load) begin
      step_nxt = last ? 2'd0 : step_r + 2'd1;
    end
    ov_nxt = load ? 1'b1 : (out_pop ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 2'd0;
      ov_r   <= 1'b0;
    end else begin
      step_r <= step_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      addr_r   <= addr_sel;
      val_r    <= val_sel;
      status_r <= q_data.status;
      last_r   <= last;
    end
  end

  assign out_empty         = !ov_r;
  assign out_byte_address  = addr_r;
  assign out_byte_value    = val_r;
  assign out_status        = status_r;
  assign out_last_of_pixel = last_r;

endmodule

@@ rtl/rgb_to_tensor_pixel_format_writer.sv @@
// ----------------------------------------------------------------------------
// rgb_to_tensor_pixel_format_writer
// Turns a raster stream of rgb pixels into byte writes of a model input
// tensor: packed or planar rgb/bgr, bt.601 gray, nv12, nv21 or i420.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_push / in_full      in_red, in_green, in_blue, in_frame_start
//  out       out_empty / out_pop    out_byte_address, out_byte_value,
//                                   out_status, out_last_of_pixel
//  config    psel, penable, pwrite  paddr, pwdata, prdata, pready
//
//  An item waits in the front register (products, then write list) until it
//  enters the queue; its writes then pass from the queue to the back output.
//  The back part gives one byte write per cycle on its single result port
//  while its output is taken, so an item yields three writes or one.
//  A four-entry queue lets the front keep accepting while the back stalls.
//  Reset clears the position and queue counters, config and all valid flags.
// ----------------------------------------------------------------------------
module rgb_to_tensor_pixel_format_writer #(
  parameter int MAX_WIDTH   = rtptf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = rtptf_pkg::MAX_HEIGHT_DEF,
  parameter int QUEUE_DEPTH = rtptf_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [7:0]                      in_red,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_blue,
  input  logic                            in_frame_start,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [rtptf_pkg::ADDR_W-1:0]    out_byte_address,
  output logic [rtptf_pkg::BYTE_W-1:0]    out_byte_value,
  output logic [rtptf_pkg::STAT_W-1:0]    out_status,
  output logic                            out_last_of_pixel,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rtptf_pkg::APB_AW-1:0]    paddr,
  input  logic [rtptf_pkg::APB_DW-1:0]    pwdata,
  output logic [rtptf_pkg::APB_DW-1:0]    prdata,
  output logic                            pready
);

  rtptf_pkg::cfg_t  cfg_r, cfg_nxt;
  rtptf_pkg::qent_t q_wr, q_rd;
  logic             q_push, q_full, q_pop, q_empty;
  logic             cfg_we;
  logic [1:0]       reg_idx;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx)
        rtptf_pkg::REG_FORMAT: cfg_nxt.fmt    = pwdata[rtptf_pkg::FMT_W-1:0];
        rtptf_pkg::REG_WIDTH:  cfg_nxt.width  = pwdata[rtptf_pkg::DIM_W-1:0];
        rtptf_pkg::REG_HEIGHT: cfg_nxt.height = pwdata[rtptf_pkg::DIM_W-1:0];
        rtptf_pkg::REG_PITCH:  cfg_nxt.pitch  = pwdata[rtptf_pkg::PITCH_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      rtptf_pkg::REG_FORMAT: prdata = rtptf_pkg::APB_DW'(cfg_r.fmt);
      rtptf_pkg::REG_WIDTH:  prdata = rtptf_pkg::APB_DW'(cfg_r.width);
      rtptf_pkg::REG_HEIGHT: prdata = rtptf_pkg::APB_DW'(cfg_r.height);
      rtptf_pkg::REG_PITCH:  prdata = rtptf_pkg::APB_DW'(cfg_r.pitch);
      default:               prdata = '0;
    endcase
  end

  // front: accept, classify, build the write list
  rtptf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_frame_start (in_frame_start),
    .q_push         (q_push),
    .q_full         (q_full),
    .q_data         (q_wr)
  );

  // queue between the two parts
  rtptf_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(rtptf_pkg::qent_t))
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  // back: one byte write per cycle unless the output stalls
  rtptf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_data            (q_rd),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_byte_address  (out_byte_address),
    .out_byte_value    (out_byte_value),
    .out_status        (out_status),
    .out_last_of_pixel (out_last_of_pixel)
  );

  // checks
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("write list pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("write list popped from an empty queue");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != rtptf_pkg::ST_OK) |->
      (out_last_of_pixel && out_byte_address == '0 && out_byte_value == '0))
    else $error("error result with payload or not last");

  a_item_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_last_of_pixel) |=> !out_empty)
    else $error("gap inside the writes of one item");

endmodule
